### design/gsps_pkg.sv
//------------------------------------------------------------------------------
// gsps_pkg
// shared constants and types for the grouped sorted position set
//------------------------------------------------------------------------------
package gsps_pkg;

  localparam int MAX_GROUPS_DEF    = 32;
  localparam int MAX_POSITIONS_DEF = 1024;
  localparam int MAX_BOUND_IDS_DEF = 16;
  localparam int POS_WIDTH_DEF     = 48;

  localparam int FUNC_W   = 2;
  localparam int GROUP_W  = 8;
  localparam int ID_W     = 16;
  localparam int STATUS_W = 2;
  localparam int OUT_POS_W = 48;

  localparam logic [FUNC_W-1:0] FUNC_INSERT  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_NEXT    = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_RESTART = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_SPARE   = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DUP  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NONE = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd3;

endpackage

### design/gsps_ram.sv
//------------------------------------------------------------------------------
// gsps_ram
// single port ram with registered read
//------------------------------------------------------------------------------
module gsps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

### design/grouped_sorted_position_set.sv
// items are handled one at a time; s_tready is high only in the idle state
// the shift of a sorted list moves one entry at a time through the position ram,
// reading it in S_SHRD and writing it one place up in S_SHWR
// reset: synchronous, clears group count, per-group counts and the iterator; rams not cleared
//------------------------------------------------------------------------------
// grouped_sorted_position_set
// groups of sorted distinct positions with per-id min/max bounds
//------------------------------------------------------------------------------
module grouped_sorted_position_set
  import gsps_pkg::*;
#(
  parameter int MAX_GROUPS    = MAX_GROUPS_DEF,
  parameter int MAX_POSITIONS = MAX_POSITIONS_DEF,
  parameter int MAX_BOUND_IDS = MAX_BOUND_IDS_DEF,
  parameter int POS_WIDTH     = POS_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // func[1:0], group_code[9:2], position[57:10], bound_id[73:58], zero fill
  input  logic [79:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // status[1:0], out_group[9:2], out_position[57:10], bound_min[105:58],
  // bound_max[153:106], zero fill
  output logic [159:0] m_tdata
);
  localparam int GW  = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int GCW = $clog2(MAX_GROUPS + 1);
  localparam int PW  = (MAX_POSITIONS > 1) ? $clog2(MAX_POSITIONS) : 1;
  localparam int PCW = $clog2(MAX_POSITIONS + 1);
  localparam int BW  = (MAX_BOUND_IDS > 1) ? $clog2(MAX_BOUND_IDS) : 1;
  localparam int BCW = $clog2(MAX_BOUND_IDS + 1);
  localparam int SD  = MAX_GROUPS * MAX_POSITIONS;
  localparam int SW  = $clog2(SD);
  localparam int BD  = MAX_GROUPS * MAX_BOUND_IDS;
  localparam int BAW = $clog2(BD);

  typedef enum logic [4:0] {
    S_IDLE, S_GRD, S_GCMP, S_PRD, S_PCMP, S_BRD, S_BCMP, S_NEWG,
    S_SHRD, S_SHWR, S_PWR, S_BUPD, S_BRES, S_NX, S_NXRD, S_NXOUT, S_OUT
  } state_t;

  state_t state;
  logic [GROUP_W-1:0] gcode;
  logic [POS_WIDTH-1:0] pos;
  logic [ID_W-1:0] bid;
  logic [GCW-1:0] group_count;
  logic [PCW-1:0] pcnt [MAX_GROUPS];
  logic [BCW-1:0] bcnt [MAX_GROUPS];
  logic [GW-1:0] g;
  logic [GCW-1:0] gi;
  logic [PCW-1:0] pi, n;
  logic [BCW-1:0] bi;
  logic dup, bfound;
  logic [GW-1:0] iter_group;
  logic [PCW-1:0] iter_index;

  logic gc_we, ps_we, bi_we, bmn_we, bmx_we;
  logic [GW-1:0] gc_addr;
  logic [SW-1:0] ps_addr;
  logic [BAW-1:0] b_addr;
  logic [GROUP_W-1:0] gc_rd;
  logic [POS_WIDTH-1:0] ps_wd, ps_rd, bmn_wd, bmx_wd, bmn_rd, bmx_rd;
  logic [ID_W-1:0] bi_rd;

  logic [STATUS_W-1:0] o_status;
  logic [GROUP_W-1:0] o_group;
  logic [POS_WIDTH-1:0] o_pos, o_min, o_max;

  gsps_ram #(.WIDTH(GROUP_W), .DEPTH(MAX_GROUPS)) u_gc (
    .clk, .we(gc_we), .addr(gc_addr), .wdata(gcode), .rdata(gc_rd));
  gsps_ram #(.WIDTH(POS_WIDTH), .DEPTH(SD)) u_ps (
    .clk, .we(ps_we), .addr(ps_addr), .wdata(ps_wd), .rdata(ps_rd));
  gsps_ram #(.WIDTH(ID_W), .DEPTH(BD)) u_bi (
    .clk, .we(bi_we), .addr(b_addr), .wdata(bid), .rdata(bi_rd));
  gsps_ram #(.WIDTH(POS_WIDTH), .DEPTH(BD)) u_bmn (
    .clk, .we(bmn_we), .addr(b_addr), .wdata(bmn_wd), .rdata(bmn_rd));
  gsps_ram #(.WIDTH(POS_WIDTH), .DEPTH(BD)) u_bmx (
    .clk, .we(bmx_we), .addr(b_addr), .wdata(bmx_wd), .rdata(bmx_rd));

  // the single shared compare unit: order keys of two positions
  logic [POS_WIDTH-1:0] cmp_a, cmp_b;
  logic cmp_eq, cmp_lt;
  logic [POS_WIDTH-1:0] sflip;
  assign sflip  = {1'b1, {(POS_WIDTH-1){1'b0}}};
  assign cmp_eq = (cmp_a == cmp_b);
  assign cmp_lt = ((cmp_a ^ sflip) < (cmp_b ^ sflip));

  always_comb begin
    cmp_a = pos;
    cmp_b = ps_rd;
    unique case (state)
      S_BUPD:  cmp_b = bmn_rd;
      S_BRES:  cmp_b = bmx_rd;
      default: cmp_b = ps_rd;
    endcase
  end

  logic [PW-1:0] pidx;
  always_comb begin
    gc_we = 1'b0; ps_we = 1'b0; bi_we = 1'b0; bmn_we = 1'b0; bmx_we = 1'b0;
    gc_addr = gi[GW-1:0];
    pidx = pi[PW-1:0];
    ps_wd = pos;
    bmn_wd = pos; bmx_wd = pos;
    b_addr = BAW'(g) * BAW'(MAX_BOUND_IDS) + BAW'(bi);
    unique case (state)
      S_NEWG: begin
        gc_we = 1'b1;
        gc_addr = group_count[GW-1:0];
      end
      S_SHRD: pidx = PW'(n - 1'b1);
      S_SHWR: begin
        pidx = n[PW-1:0];
        ps_we = 1'b1;
        ps_wd = ps_rd;
      end
      S_PWR: ps_we = 1'b1;
      S_BUPD: begin
        bi_we = !bfound;
        bmn_we = !bfound || cmp_lt;
        bmx_we = !bfound;
      end
      S_BRES: bmx_we = bfound && !cmp_lt && !cmp_eq;
      S_NX, S_NXRD: begin
        gc_addr = iter_group;
        pidx = iter_index[PW-1:0];
      end
      default: ;
    endcase
    if (state == S_NX || state == S_NXRD) begin
      ps_addr = SW'(iter_group) * SW'(MAX_POSITIONS) + SW'(pidx);
    end else begin
      ps_addr = SW'(g) * SW'(MAX_POSITIONS) + SW'(pidx);
    end
  end

  assign s_tready = (state == S_IDLE);
  assign m_tdata = {6'd0, OUT_POS_W'(signed'(o_max)), OUT_POS_W'(signed'(o_min)),
                    OUT_POS_W'(signed'(o_pos)), o_group, o_status};

  logic [PCW-1:0] cur_cnt;
  assign cur_cnt = pcnt[g];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      m_tvalid <= 1'b0;
      group_count <= '0;
      iter_group <= '0;
      iter_index <= '0;
      for (int k = 0; k < MAX_GROUPS; k++) begin
        pcnt[k] <= '0;
        bcnt[k] <= '0;
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            gcode <= s_tdata[9:2];
            pos   <= POS_WIDTH'(signed'(s_tdata[57:10]));
            bid   <= s_tdata[73:58];
            gi <= '0; pi <= '0; bi <= '0; dup <= 1'b0; bfound <= 1'b0;
            o_status <= ST_OK; o_group <= s_tdata[9:2];
            o_pos <= '0; o_min <= '0; o_max <= '0;
            if (s_tdata[1:0] == FUNC_INSERT) begin
              state <= S_GRD;
            end else if (group_count == '0) begin
              o_status <= ST_NONE; o_group <= '0;
              state <= S_OUT;
            end else begin
              if (s_tdata[1:0] == FUNC_RESTART) begin
                iter_group <= '0;
                iter_index <= '0;
              end
              state <= S_NX;
            end
          end
        end
        S_GRD: begin
          if (gi >= group_count) begin
            if (group_count >= GCW'(MAX_GROUPS)) begin
              o_status <= ST_FULL;
              state <= S_OUT;
            end else begin
              g <= group_count[GW-1:0];
              state <= S_NEWG;
            end
          end else begin
            state <= S_GCMP;
          end
        end
        S_GCMP: begin
          if (gc_rd == gcode) begin
            g <= gi[GW-1:0];
            state <= S_PRD;
          end else begin
            gi <= gi + 1'b1;
            state <= S_GRD;
          end
        end
        S_NEWG: begin
          group_count <= group_count + 1'b1;
          pcnt[g] <= '0;
          bcnt[g] <= '0;
          n <= '0;
          pi <= '0;
          state <= S_PWR;
        end
        S_PRD: begin
          if (pi >= cur_cnt) begin
            state <= S_BRD;
          end else begin
            state <= S_PCMP;
          end
        end
        S_PCMP: begin
          if (cmp_eq) begin
            dup <= 1'b1;
            state <= S_BRD;
          end else if (cmp_lt) begin
            state <= S_BRD;
          end else begin
            pi <= pi + 1'b1;
            state <= S_PRD;
          end
        end
        S_BRD: begin
          if (!dup && cur_cnt >= PCW'(MAX_POSITIONS)) begin
            o_status <= ST_FULL;
            state <= S_OUT;
          end else if (bi >= bcnt[g]) begin
            if (bcnt[g] >= BCW'(MAX_BOUND_IDS)) begin
              o_status <= ST_FULL;
              state <= S_OUT;
            end else begin
              n <= cur_cnt;
              state <= dup ? S_BUPD : S_SHRD;
            end
          end else begin
            state <= S_BCMP;
          end
        end
        S_BCMP: begin
          if (bi_rd == bid) begin
            bfound <= 1'b1;
            n <= cur_cnt;
            state <= dup ? S_BUPD : S_SHRD;
          end else begin
            bi <= bi + 1'b1;
            state <= S_BRD;
          end
        end
        S_SHRD: begin
          if (n > pi) begin
            state <= S_SHWR;
          end else begin
            state <= S_PWR;
          end
        end
        S_SHWR: begin
          n <= n - 1'b1;
          state <= S_SHRD;
        end
        S_PWR: begin
          pcnt[g] <= cur_cnt + 1'b1;
          state <= S_BUPD;
        end
        S_BUPD: begin
          if (!bfound) begin
            bi <= bcnt[g];
            bcnt[g] <= bcnt[g] + 1'b1;
          end
          o_min <= (bfound && !cmp_lt) ? bmn_rd : pos;
          state <= S_BRES;
        end
        S_BRES: begin
          o_status <= dup ? ST_DUP : ST_OK;
          if (bfound) begin
            o_max <= (!cmp_lt && !cmp_eq) ? pos : bmx_rd;
          end else begin
            o_max <= pos;
          end
          state <= S_OUT;
        end
        S_NX: begin
          if (GCW'(iter_group) < group_count && iter_index < pcnt[iter_group]) begin
            state <= S_NXRD;
          end else if (GCW'(iter_group) + 1'b1 < group_count) begin
            iter_group <= iter_group + 1'b1;
            iter_index <= '0;
            if (pcnt[iter_group + 1'b1] == '0) begin
              o_status <= ST_NONE; o_group <= '0;
              state <= S_OUT;
            end else begin
              state <= S_NXRD;
            end
          end else begin
            o_status <= ST_NONE; o_group <= '0;
            state <= S_OUT;
          end
        end
        S_NXRD: state <= S_NXOUT;
        S_NXOUT: begin
          o_status <= ST_OK;
          o_group <= gc_rd;
          o_pos <= ps_rd;
          iter_index <= iter_index + 1'b1;
          state <= S_OUT;
        end
        S_OUT: begin
          if (!m_tvalid) begin
            m_tvalid <= 1'b1;
          end else if (m_tready) begin
            m_tvalid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) m_tvalid |-> state == S_OUT)
    else $error("result shown outside output state");
  assert property (@(posedge clk) disable iff (rst) s_tready |-> !m_tvalid)
    else $error("ready while result pending");
  assert property (@(posedge clk) disable iff (rst) group_count <= GCW'(MAX_GROUPS))
    else $error("group count overflow");
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[1:0] == ST_FULL) |-> m_tdata[57:10] == '0)
    else $error("full result carries a position");
endmodule

### tb/gsps_checker.sv
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// gsps_checker
// watches both streams of the grouped sorted position set, keeps its own
// copy of the groups, positions, id bounds and iterator, and compares every
// output item field by field with the oldest expected one
//------------------------------------------------------------------------------
module gsps_checker
  import gsps_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [79:0]  s_tdata,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [159:0] m_tdata,
  output int           errors,
  output int           pending
);

  localparam int NG = MAX_GROUPS_DEF;
  localparam int NP = MAX_POSITIONS_DEF;
  localparam int NB = MAX_BOUND_IDS_DEF;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [GROUP_W-1:0]   grp;
    logic signed [47:0]   pos;
    logic signed [47:0]   bmin;
    logic signed [47:0]   bmax;
  } result_t;

  logic [GROUP_W-1:0] grp_code [NG];
  int                 grp_cnt;
  logic signed [47:0] pos_list [NG][NP];
  int                 pos_cnt [NG];
  logic [ID_W-1:0]    id_tab [NG][NB];
  logic signed [47:0] id_min [NG][NB];
  logic signed [47:0] id_max [NG][NB];
  int                 id_cnt [NG];
  int                 it_grp;
  int                 it_idx;

  result_t expected_q[$];

  function automatic result_t insert_position(logic [GROUP_W-1:0] gc,
                                              logic signed [47:0] p,
                                              logic [ID_W-1:0] id);
    result_t r;
    int g, i, b, n, k;
    bit found, dup, bfound;
    r = '0;
    r.grp = gc;
    found = 0; dup = 0; bfound = 0;
    g = 0; i = 0; b = 0;
    for (g = 0; g < grp_cnt; g++)
      if (grp_code[g] == gc) begin
        found = 1;
        break;
      end
    if (!found && grp_cnt >= NG) begin
      r.status = ST_FULL;
      return r;
    end
    if (found) begin
      n = pos_cnt[g];
      for (i = 0; i < n; i++) begin
        if (pos_list[g][i] == p) begin
          dup = 1;
          break;
        end
        if (p < pos_list[g][i]) break;
      end
      if (!dup && n >= NP) begin
        r.status = ST_FULL;
        return r;
      end
      for (b = 0; b < id_cnt[g]; b++)
        if (id_tab[g][b] == id) begin
          bfound = 1;
          break;
        end
      if (!bfound && id_cnt[g] >= NB) begin
        r.status = ST_FULL;
        return r;
      end
    end else begin
      g = grp_cnt;
      grp_code[g] = gc;
      pos_cnt[g] = 0;
      id_cnt[g] = 0;
      grp_cnt++;
    end
    if (!dup) begin
      n = pos_cnt[g];
      for (k = n; k > i; k--) pos_list[g][k] = pos_list[g][k-1];
      pos_list[g][i] = p;
      pos_cnt[g] = n + 1;
    end
    if (bfound) begin
      if (id_min[g][b] > p) id_min[g][b] = p;
      if (id_max[g][b] < p) id_max[g][b] = p;
    end else begin
      b = id_cnt[g];
      id_tab[g][b] = id;
      id_min[g][b] = p;
      id_max[g][b] = p;
      id_cnt[g] = b + 1;
    end
    r.status = dup ? ST_DUP : ST_OK;
    r.bmin = id_min[g][b];
    r.bmax = id_max[g][b];
    return r;
  endfunction

  function automatic result_t next_position(bit restart);
    result_t r;
    r = '0;
    r.status = ST_NONE;
    if (grp_cnt == 0) return r;
    if (restart) begin
      it_grp = 0;
      it_idx = 0;
    end
    if (it_grp < grp_cnt && it_idx < pos_cnt[it_grp]) begin
    end else if (it_grp + 1 < grp_cnt) begin
      it_grp++;
      it_idx = 0;
      if (pos_cnt[it_grp] == 0) return r;
    end else begin
      return r;
    end
    r.status = ST_OK;
    r.grp = grp_code[it_grp];
    r.pos = pos_list[it_grp][it_idx];
    it_idx++;
    return r;
  endfunction

  result_t got, want;
  logic [FUNC_W-1:0] fn;

  always @(posedge clk) begin
    if (rst) begin
      grp_cnt <= 0;
      it_grp <= 0;
      it_idx <= 0;
      for (int g = 0; g < NG; g++) begin
        pos_cnt[g] = 0;
        id_cnt[g] = 0;
      end
      expected_q.delete();
      errors <= 0;
      pending <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        fn = s_tdata[1:0];
        if (fn == FUNC_INSERT)
          expected_q.push_back(insert_position(s_tdata[9:2], s_tdata[57:10],
                                               s_tdata[73:58]));
        else
          expected_q.push_back(next_position(fn == FUNC_RESTART));
      end
      if (m_tvalid && m_tready) begin
        got = {m_tdata[1:0], m_tdata[9:2], m_tdata[57:10], m_tdata[105:58],
               m_tdata[153:106]};
        if (expected_q.size() == 0) begin
          errors <= errors + 1;
          if (errors < 10) $display("unexpected output item %h", got);
        end else begin
          want = expected_q.pop_front();
          if (got.status !== want.status || got.grp !== want.grp ||
              got.pos !== want.pos || got.bmin !== want.bmin ||
              got.bmax !== want.bmax) begin
            errors <= errors + 1;
            if (errors < 10)
              $display("mismatch: status %0d/%0d group %0d/%0d pos %0d/%0d min %0d/%0d max %0d/%0d",
                       want.status, got.status, want.grp, got.grp, want.pos, got.pos,
                       want.bmin, got.bmin, want.bmax, got.bmax);
          end
        end
      end
      pending <= expected_q.size();
    end
  end

endmodule

### tb/tb_grouped_sorted_position_set.sv
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// tb_grouped_sorted_position_set
// drives directed and random insert, next and restart items into the
// grouped sorted position set under several idle and stall patterns; the
// checker predicts and compares, this module gives the verdict
//------------------------------------------------------------------------------
module tb_grouped_sorted_position_set;
  import gsps_pkg::*;

  logic         clk = 0;
  logic         rst = 1;
  logic         s_tvalid = 0;
  logic         s_tready;
  logic [79:0]  s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 0;
  logic [159:0] m_tdata;
  int           errors;
  int           pending;
  int           idle_pct = 0;
  int           stall_pct = 0;
  logic [GROUP_W-1:0] code_pool [12];

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  grouped_sorted_position_set u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  gsps_checker u_chk (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .errors(errors), .pending(pending)
  );

  always @(posedge clk) m_tready <= ($urandom_range(99) >= stall_pct);

  task automatic send_item(logic [FUNC_W-1:0] fn, logic [GROUP_W-1:0] gc,
                           logic signed [47:0] p, logic [ID_W-1:0] id);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 0;
      @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= {6'd0, id, p, gc, fn};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic wait_drain();
    s_tvalid <= 0;
    @(posedge clk);
    while (pending != 0 || m_tvalid) @(posedge clk);
  endtask

  function automatic logic signed [47:0] pick_position();
    case ($urandom_range(5))
      0: return 48'({$urandom, $urandom});
      1: return 48'sh7FFF_FFFF_FFFF - $urandom_range(2);
      2: return 48'sh8000_0000_0000 + $urandom_range(2);
      3: return $signed(48'($urandom_range(40))) - 20;
      default: return 48'({$urandom_range(65535), $urandom});
    endcase
  endfunction

  task automatic random_item();
    int r;
    r = $urandom_range(99);
    if (r < 62)
      send_item(FUNC_INSERT,
                ($urandom_range(9) == 0) ? 8'($urandom) : code_pool[$urandom_range(11)],
                pick_position(),
                ($urandom_range(4) == 0) ? 16'($urandom) : 16'($urandom_range(5)));
    else if (r < 88)
      send_item(FUNC_NEXT, 8'($urandom), 48'({$urandom, $urandom}), 16'($urandom));
    else if (r < 95)
      send_item(FUNC_RESTART, 8'($urandom), 48'({$urandom, $urandom}), 16'($urandom));
    else
      send_item(FUNC_SPARE, 8'($urandom), 48'({$urandom, $urandom}), 16'($urandom));
  endtask

  initial begin
    #(4 * 1000 * 1000 * 5);
    $display("grouped_sorted_position_set regression: fail");
    $finish;
  end

  initial begin
    for (int i = 0; i < 12; i++) code_pool[i] = 8'($urandom);
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // empty store, extremes, duplicates, bound widening, iteration past the end and restart
    send_item(FUNC_RESTART, 8'h00, '0, '0);
    send_item(FUNC_NEXT, 8'h00, '0, '0);
    send_item(FUNC_INSERT, 8'h00, 48'sh7FFF_FFFF_FFFF, 16'h0000);
    send_item(FUNC_INSERT, 8'h00, 48'sh8000_0000_0000, 16'h0000);
    send_item(FUNC_INSERT, 8'h00, 48'sh0, 16'hFFFF);
    send_item(FUNC_INSERT, 8'h00, 48'sh0, 16'hFFFF);
    send_item(FUNC_INSERT, 8'h00, 48'sh0, 16'h0000);
    send_item(FUNC_INSERT, 8'hFF, -48'sh1_0000, 16'hFFFF);
    send_item(FUNC_INSERT, 8'hFF, 48'sh1_0000, 16'hFFFF);
    send_item(FUNC_INSERT, 8'hFF, -48'sh1_0000, 16'h1234);
    send_item(FUNC_INSERT, 8'h5A, 48'sh5555_5555_5555, 16'hAAAA);
    for (int i = 0; i < 8; i++) send_item(FUNC_NEXT, '0, '0, '0);
    send_item(FUNC_SPARE, 8'hFF, 48'sh7FFF_FFFF_FFFF, 16'hFFFF);
    send_item(FUNC_RESTART, 8'hFF, '1, '1);
    send_item(FUNC_NEXT, '0, '0, '0);
    wait_drain();

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = (ph == 1 || ph == 3) ? ((ph == 3) ? 16 : 86) : 0;
      stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 16 : 86) : 0;
      for (int n = 0; n < 110; n++) random_item();
      if (ph == 1) wait_drain();
    end
    idle_pct = 0;
    stall_pct = 0;

    // exhaust the id table of one group, then the group table
    for (int i = 0; i < 18; i++)
      send_item(FUNC_INSERT, 8'hC3, 48'(i * 3), 16'(16'h8000 + i));
    for (int i = 0; i < 40; i++)
      send_item(FUNC_INSERT, 8'(i * 6 + 1), 48'(i), 16'(i));
    for (int n = 0; n < 20; n++) random_item();

    wait_drain();
    repeat (50) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("grouped_sorted_position_set regression: pass");
    else
      $display("grouped_sorted_position_set regression: fail");
    $finish;
  end

endmodule
